[hdl/ctp_pkg.sv]
// ctp_pkg: shared types, widths and reset constants for the countdown timer
// panel controller. No dependencies; every other file in hdl uses it.

package ctp_pkg;

  localparam int DIAL_BITS_DEF = 12;
  localparam int TIME_BITS_DEF = 32;

  localparam int DUR_W   = 25;
  localparam int MS16_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

  localparam logic [MS16_W-1:0] RST_LONG_PRESS = 16'd800;
  localparam logic [DUR_W-1:0]  RST_MIN_DUR    = 25'd5000;
  localparam logic [DUR_W-1:0]  RST_MAX_DUR    = 25'd18000000;
  localparam logic [DUR_W-1:0]  RST_SPAN       = RST_MAX_DUR - RST_MIN_DUR;
  localparam logic [MS16_W-1:0] RST_BUZZ_HALF  = 16'd500;
  localparam logic [DUR_W-1:0]  RST_CD_LEN     = 25'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_MIN_DUR    = 2'd1,
    CFG_MAX_DUR    = 2'd2,
    CFG_BUZZ_HALF  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TM_TIMER     = 2'd0,
    TM_STOPWATCH = 2'd1,
    TM_ALARM     = 2'd2
  } tmode_e;

  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_GREEN = 2'd1,
    COL_BLUE  = 2'd2
  } colour_e;

  // settings seen by the datapath; span is kept precomputed
  typedef struct packed {
    logic [MS16_W-1:0] long_press;
    logic [MS16_W-1:0] buzz_half;
    logic [DUR_W-1:0]  min_dur;
    logic [DUR_W-1:0]  span;
  } cfg_t;

  // one tick after dial scaling
  typedef struct packed {
    logic               level;
    logic               mpress;
    logic [LEVEL_W-1:0] bri;
    logic [DUR_W-1:0]   dur;
  } dial_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               tone;
    logic               beep;
    tmode_e             timing_mode;
    logic               knob;
    logic               running;
    logic               ringing;
    logic [DUR_W-1:0]   dur;
  } res_t;

endpackage

[hdl/ctp_dial_pipe.sv]
// ctp_dial_pipe: pipelined dial scaling, brightness and countdown duration.
// Division by 2^DIAL_BITS-1 is done by fold stages. Depends on ctp_pkg.

module ctp_dial_pipe #(
  parameter int DIAL_BITS = ctp_pkg::DIAL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   alarm_button_level,
  input  logic                   mode_press,
  input  logic [DIAL_BITS-1:0]   dial_sample,
  input  ctp_pkg::cfg_t          cfg,
  output logic                   pipe_valid,
  input  logic                   pipe_ready,
  output ctp_pkg::dial_item_t    pipe_item
);

  localparam int N     = DIAL_BITS;
  localparam int DW    = ctp_pkg::DUR_W;
  localparam int PW    = N + DW;
  localparam int BW    = N + ctp_pkg::LEVEL_W;
  localparam int FOLDS = (DW + N - 1) / N + 1;
  localparam int NS    = FOLDS + 3;
  localparam logic [PW-1:0] DMAX_P = PW'((1 << N) - 1);
  localparam logic [BW-1:0] DMAX_B = BW'((1 << N) - 1);

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic [NS-2:0] lvl;
  logic [NS-2:0] mp;
  logic [N-1:0]  dial_r;
  logic [PW-1:0] y  [FOLDS+1];
  logic [PW-1:0] q  [FOLDS+1];
  logic [BW-1:0] yb [FOLDS+1];
  logic [BW-1:0] qb [FOLDS+1];

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || pipe_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign item_stall = !rdy[0];
  assign pipe_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lvl[0] <= alarm_button_level;
      mp[0]  <= mode_press;
      dial_r <= dial_sample;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        lvl[k] <= lvl[k-1];
        mp[k]  <= mp[k-1];
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      y[0]  <= PW'(dial_r) * PW'(cfg.span);
      q[0]  <= '0;
      yb[0] <= BW'(dial_r) * BW'(ctp_pkg::LEVEL_FULL);
      qb[0] <= '0;
    end
  end

  // x = q*D + y holds at every fold; y shrinks by N bits each time
  for (genvar j = 1; j <= FOLDS; j++) begin : g_fold
    always_ff @(posedge clk) begin
      if (rdy[j+1]) begin
        y[j]  <= (y[j-1] & DMAX_P) + (y[j-1] >> N);
        q[j]  <= q[j-1] + (y[j-1] >> N);
        yb[j] <= (yb[j-1] & DMAX_B) + (yb[j-1] >> N);
        qb[j] <= qb[j-1] + (yb[j-1] >> N);
      end
    end
  end

  // remainder is below 2*D here, so one correction finishes the quotient
  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      pipe_item.level  <= lvl[NS-2];
      pipe_item.mpress <= mp[NS-2];
      pipe_item.bri    <= qb[FOLDS][ctp_pkg::LEVEL_W-1:0]
                          + ctp_pkg::LEVEL_W'(yb[FOLDS] >= DMAX_B);
      pipe_item.dur    <= cfg.min_dur + q[FOLDS][DW-1:0] + DW'(y[FOLDS] >= DMAX_P);
    end
  end

endmodule

[hdl/ctp_panel_core.sv]
// ctp_panel_core: per-tick panel state (buttons, countdown, buzzer, LEDs)
// and the result register. Depends on ctp_pkg.

module ctp_panel_core #(
  parameter int TIME_BITS = ctp_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pipe_valid,
  output logic                pipe_ready,
  input  ctp_pkg::dial_item_t pipe_item,
  input  ctp_pkg::cfg_t       cfg,
  output logic                result_valid,
  input  logic                result_stall,
  output ctp_pkg::res_t       res
);

  localparam int TW = TIME_BITS;
  localparam int DW = ctp_pkg::DUR_W;
  localparam int LW = ctp_pkg::LEVEL_W;

  logic [TW-1:0]    now_ms, now_ms_next;
  logic [TW-1:0]    cd_start, cd_start_next;
  logic [DW-1:0]    cd_len, cd_len_next;
  logic [TW-1:0]    press_start, press_start_next;
  logic             press_active, press_active_next;
  ctp_pkg::tmode_e  tmode, tmode_next;
  ctp_pkg::colour_e colour, colour_next;
  logic             knob_sel, knob_sel_next;
  logic             running, running_next;
  logic             ringing, ringing_next;
  logic [LW-1:0]    bright, bright_next;
  logic [TW-1:0]    buzz_mark, buzz_mark_next;
  logic             buzz_phase, buzz_phase_next;
  logic             tone, tone_next;

  logic             beep;
  logic [LW-1:0]    red_d, green_d, blue_d;
  logic [TW-1:0]    press_elapsed, cd_elapsed, buzz_elapsed;
  logic             take;

  assign pipe_ready = !result_valid || !result_stall;
  assign take       = pipe_valid && pipe_ready;

  always_comb begin
    now_ms_next       = now_ms + TW'(1);
    cd_start_next     = cd_start;
    cd_len_next       = cd_len;
    press_start_next  = press_start;
    press_active_next = press_active;
    tmode_next        = tmode;
    colour_next       = colour;
    knob_sel_next     = knob_sel;
    running_next      = running;
    ringing_next      = ringing;
    bright_next       = bright;
    buzz_mark_next    = buzz_mark;
    buzz_phase_next   = buzz_phase;
    tone_next         = tone;
    beep              = 1'b0;
    press_elapsed     = now_ms - press_start;
    buzz_elapsed      = now_ms - buzz_mark;

    if (!knob_sel) begin
      bright_next = pipe_item.bri;
    end else begin
      cd_len_next = pipe_item.dur;
    end

    if (pipe_item.mpress) begin
      case (colour)
        ctp_pkg::COL_RED:   colour_next = ctp_pkg::COL_GREEN;
        ctp_pkg::COL_GREEN: colour_next = ctp_pkg::COL_BLUE;
        default:            colour_next = ctp_pkg::COL_RED;
      endcase
      beep      = 1'b1;
      tone_next = 1'b0;
    end

    if (!pipe_item.level && !press_active) begin
      press_start_next  = now_ms;
      press_active_next = 1'b1;
    end else if (pipe_item.level && press_active) begin
      if (press_elapsed >= TW'(cfg.long_press)) begin
        case (tmode)
          ctp_pkg::TM_TIMER:     tmode_next = ctp_pkg::TM_STOPWATCH;
          ctp_pkg::TM_STOPWATCH: tmode_next = ctp_pkg::TM_ALARM;
          default:               tmode_next = ctp_pkg::TM_TIMER;
        endcase
        knob_sel_next = 1'b0;
        beep          = 1'b1;
        tone_next     = 1'b0;
      end else if (tmode == ctp_pkg::TM_TIMER) begin
        if (ringing) begin
          // silence the alarm, no acknowledge beep
          ringing_next = 1'b0;
          tone_next    = 1'b0;
        end else if (running) begin
          running_next = 1'b0;
          beep         = 1'b1;
          tone_next    = 1'b0;
        end else if (!knob_sel) begin
          knob_sel_next = 1'b1;
          beep          = 1'b1;
          tone_next     = 1'b0;
        end else begin
          knob_sel_next = 1'b0;
          running_next  = 1'b1;
          cd_start_next = now_ms;
          beep          = 1'b1;
          tone_next     = 1'b0;
        end
      end else if (tmode == ctp_pkg::TM_STOPWATCH || tmode == ctp_pkg::TM_ALARM) begin
        beep      = 1'b1;
        tone_next = 1'b0;
      end
      press_active_next = 1'b0;
    end

    red_d   = ctp_pkg::LEVEL_FULL;
    green_d = ctp_pkg::LEVEL_FULL;
    blue_d  = ctp_pkg::LEVEL_FULL;
    case (colour_next)
      ctp_pkg::COL_RED:   red_d   = ctp_pkg::LEVEL_FULL - bright_next;
      ctp_pkg::COL_GREEN: green_d = ctp_pkg::LEVEL_FULL - bright_next;
      ctp_pkg::COL_BLUE:  blue_d  = ctp_pkg::LEVEL_FULL - bright_next;
      default: ;
    endcase

    // a countdown started this tick is measured from now
    cd_elapsed = now_ms - cd_start_next;
    if (running_next && cd_elapsed >= TW'(cd_len_next)) begin
      running_next = 1'b0;
      ringing_next = 1'b1;
    end

    if (ringing_next) begin
      if (buzz_elapsed >= TW'(cfg.buzz_half)) begin
        buzz_mark_next  = now_ms;
        buzz_phase_next = !buzz_phase;
        tone_next       = !buzz_phase;
      end
    end else begin
      tone_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      now_ms       <= '0;
      cd_start     <= '0;
      cd_len       <= ctp_pkg::RST_CD_LEN;
      press_start  <= '0;
      press_active <= 1'b0;
      tmode        <= ctp_pkg::TM_TIMER;
      colour       <= ctp_pkg::COL_RED;
      knob_sel     <= 1'b0;
      running      <= 1'b0;
      ringing      <= 1'b0;
      bright       <= ctp_pkg::LEVEL_FULL;
      buzz_mark    <= '0;
      buzz_phase   <= 1'b0;
      tone         <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
      now_ms       <= now_ms_next;
      cd_start     <= cd_start_next;
      cd_len       <= cd_len_next;
      press_start  <= press_start_next;
      press_active <= press_active_next;
      tmode        <= tmode_next;
      colour       <= colour_next;
      knob_sel     <= knob_sel_next;
      running      <= running_next;
      ringing      <= ringing_next;
      bright       <= bright_next;
      buzz_mark    <= buzz_mark_next;
      buzz_phase   <= buzz_phase_next;
      tone         <= tone_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.red         <= red_d;
      res.green       <= green_d;
      res.blue        <= blue_d;
      res.tone        <= tone_next;
      res.beep        <= beep;
      res.timing_mode <= tmode_next;
      res.knob        <= knob_sel_next;
      res.running     <= running_next;
      res.ringing     <= ringing_next;
      res.dur         <= cd_len_next;
    end
  end

endmodule

[hdl/countdown_timer_panel_controller.sv]
// A request passes through the input register, the dial multiply, the
// fold stages of the divide by 2^DIAL_BITS-1, the duration add and the
// result register. Throughput: one request per cycle; a stalled result
// holds only the stages behind it that are full. Synchronous rst empties
// the pipeline and loads all settings and panel state with their
// power-on values at once.

module countdown_timer_panel_controller #(
  parameter int DIAL_BITS = ctp_pkg::DIAL_BITS_DEF,
  parameter int TIME_BITS = ctp_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctp_pkg::DUR_W-1:0]       cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            alarm_button_level,
  input  logic                            mode_press,
  input  logic [DIAL_BITS-1:0]            dial_sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [ctp_pkg::LEVEL_W-1:0]     red_drive,
  output logic [ctp_pkg::LEVEL_W-1:0]     green_drive,
  output logic [ctp_pkg::LEVEL_W-1:0]     blue_drive,
  output logic                            tone_on,
  output logic                            beep_pulse,
  output logic [1:0]                      timing_mode,
  output logic                            dial_target,
  output logic                            timer_running,
  output logic                            alarm_ringing,
  output logic [ctp_pkg::DUR_W-1:0]       duration_now_ms
);

  localparam int DW = ctp_pkg::DUR_W;
  localparam int HW = ctp_pkg::MS16_W;

  logic [HW-1:0] long_press;
  logic [DW-1:0] min_dur;
  logic [DW-1:0] max_dur;
  logic [HW-1:0] buzz_half;
  logic [DW-1:0] span;

  ctp_pkg::cfg_t       cfg;
  ctp_pkg::dial_item_t pipe_item;
  ctp_pkg::res_t       res;
  logic                pipe_valid;
  logic                pipe_ready;

  function automatic logic [DW-1:0] span_of(input logic [DW-1:0] hi, input logic [DW-1:0] lo);
    return (hi >= lo) ? hi - lo : '0;
  endfunction

  assign cfg_ready = 1'b1;

  // span follows every write of min or max
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press <= ctp_pkg::RST_LONG_PRESS;
      min_dur    <= ctp_pkg::RST_MIN_DUR;
      max_dur    <= ctp_pkg::RST_MAX_DUR;
      buzz_half  <= ctp_pkg::RST_BUZZ_HALF;
      span       <= ctp_pkg::RST_SPAN;
    end else if (cfg_valid) begin
      case (ctp_pkg::cfg_reg_e'(cfg_index))
        ctp_pkg::CFG_LONG_PRESS: long_press <= cfg_data[HW-1:0];
        ctp_pkg::CFG_MIN_DUR: begin
          min_dur <= cfg_data;
          span    <= span_of(max_dur, cfg_data);
        end
        ctp_pkg::CFG_MAX_DUR: begin
          max_dur <= cfg_data;
          span    <= span_of(cfg_data, min_dur);
        end
        ctp_pkg::CFG_BUZZ_HALF: buzz_half <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.long_press = long_press;
  assign cfg.buzz_half  = buzz_half;
  assign cfg.min_dur    = min_dur;
  assign cfg.span       = span;

  ctp_dial_pipe #(
    .DIAL_BITS (DIAL_BITS)
  ) u_dial (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .alarm_button_level (alarm_button_level),
    .mode_press         (mode_press),
    .dial_sample        (dial_sample),
    .cfg                (cfg),
    .pipe_valid         (pipe_valid),
    .pipe_ready         (pipe_ready),
    .pipe_item          (pipe_item)
  );

  ctp_panel_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .pipe_valid   (pipe_valid),
    .pipe_ready   (pipe_ready),
    .pipe_item    (pipe_item),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res          (res)
  );

  assign red_drive       = res.red;
  assign green_drive     = res.green;
  assign blue_drive      = res.blue;
  assign tone_on         = res.tone;
  assign beep_pulse      = res.beep;
  assign timing_mode     = res.timing_mode;
  assign dial_target     = res.knob;
  assign timer_running   = res.running;
  assign alarm_ringing   = res.ringing;
  assign duration_now_ms = res.dur;

endmodule

[hdl/ctp_checker.sv]
// ctp_checker: port-level checks on the result channel of the panel
// controller, bound to the top level. Depends on ctp_pkg.

module ctp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [ctp_pkg::LEVEL_W-1:0] red_drive,
  input logic [ctp_pkg::LEVEL_W-1:0] green_drive,
  input logic [ctp_pkg::LEVEL_W-1:0] blue_drive,
  input logic                        tone_on,
  input logic                        dial_target,
  input logic                        timer_running,
  input logic                        alarm_ringing
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(red_drive)
      && $stable(tone_on) && $stable(alarm_ringing))
    else $error("stalled result changed");

  a_run_ring_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(timer_running && alarm_ringing))
    else $error("running and ringing together");

  a_tone_needs_ring: assert property (@(posedge clk) disable iff (rst)
    result_valid && tone_on |-> alarm_ringing)
    else $error("tone on while not ringing");

  a_run_knob: assert property (@(posedge clk) disable iff (rst)
    result_valid && timer_running |-> !dial_target)
    else $error("knob on duration while running");

  a_one_colour: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (red_drive == ctp_pkg::LEVEL_FULL && green_drive == ctp_pkg::LEVEL_FULL) ||
      (red_drive == ctp_pkg::LEVEL_FULL && blue_drive == ctp_pkg::LEVEL_FULL) ||
      (green_drive == ctp_pkg::LEVEL_FULL && blue_drive == ctp_pkg::LEVEL_FULL))
    else $error("more than one colour lit");

endmodule

bind countdown_timer_panel_controller ctp_checker u_ctp_checker (.*);
